FILE: hdl/canonical_huffman_table_builder_top_assert.svh
// assertion macros for the canonical huffman table builder
// used by canonical_huffman_table_builder_top, expects clk and rst_n in scope
`ifndef CANONICAL_HUFFMAN_TABLE_BUILDER_TOP_ASSERT_SVH
`define CANONICAL_HUFFMAN_TABLE_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define CHTB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CHTB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CHTB_ASSERT_IMP(label, ante, cons)
`define CHTB_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hdl/chtb_pkg.sv
// shared types and constants for the canonical huffman table builder
// no dependencies
`default_nettype none
package chtb_pkg;
    localparam int NUM_SYMBOLS = 256;
    localparam int MAX_LEN     = 32;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 6;
    localparam int ROW_IDX_W   = 5;
    localparam int CNT_W       = 9;
    localparam int CODE_W      = 32;
    localparam int CUR_W       = 41;
    localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(NUM_SYMBOLS);
    localparam logic [CNT_W-1:0] ROW_LAST  = CNT_W'(MAX_LEN - 1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LEN);

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_CODE  = 2'd1,
        FUNC_ROW   = 2'd2,
        FUNC_ENTRY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_LARGE = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_OVER      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_ROWS,
        ST_ASSIGN,
        ST_RD1,
        ST_RD2,
        ST_RD3
    } state_t;

    typedef struct packed {
        logic             start;
        logic             count_en;
        logic             row_en;
        logic             assign_en;
        logic [LEN_W-1:0] count_len;
        logic [LEN_W-1:0] row_len;
        logic [LEN_W-1:0] assign_len;
        logic [LEN_W-1:0] rd_len;
    } row_ctrl_t;

    typedef struct packed {
        logic [CODE_W-1:0] assign_code;
        logic [SYM_W-1:0]  assign_index;
        logic [CODE_W-1:0] rd_base;
        logic [CNT_W-1:0]  rd_start;
        logic [CNT_W-1:0]  rd_size;
        logic [CNT_W-1:0]  used;
        logic [LEN_W-1:0]  longest;
        logic              over;
    } row_stat_t;
endpackage
`default_nettype wire

FILE: hdl/canonical_huffman_table_builder_top.sv
// Canonical huffman table builder: length store, code store, sorted list.
// Depends on chtb_pkg, chtb_row_unit and canonical_huffman_table_builder_top_assert.svh.
//
// One request channel (in_valid/in_stall) and one result channel
// (out_valid/out_stall). Each request gives exactly one result.
// func 0 stores a symbol's code length; lengths above 32 are refused with
// status 1. funcs 1 to 3 read a symbol's code, a length row or a sorted entry.
// A write's result is registered when it is accepted. A read goes through
// the states RD1 and RD2, a sorted entry also through RD3 (two chained
// memory reads). The first read after a stored length write rebuilds the
// tables first: a length histogram, a row build through the shared shifter
// and code assignment; histogram and assignment each make one pass per
// symbol over the length memory port. One request is handled at a time;
// in_stall is high while the block works and while a result waits. The
// result is held until out_stall is low. After reset a clearing pass
// zeroes the length store, with in_stall high.
`default_nettype none
module canonical_huffman_table_builder_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [7:0]        symbol,
    input  logic [5:0]        length,
    input  logic [5:0]        row_length,
    input  logic [7:0]        entry_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [31:0]       code,
    output logic [5:0]        code_length,
    output logic [31:0]       row_base_code,
    output logic signed [8:0] row_start_index,
    output logic [8:0]        row_count,
    output logic [7:0]        sorted_symbol,
    output logic [8:0]        used_count,
    output logic [5:0]        max_length
);
    `include "canonical_huffman_table_builder_top_assert.svh"

    chtb_pkg::state_t state_reg, state_next;
    logic [8:0] sweep_reg, sweep_next;
    logic       stale_reg, stale_next;
    logic       built_reg, built_next;
    logic [1:0] req_func_reg, req_func_next;
    logic [7:0] req_sym_reg, req_sym_next;
    logic [5:0] req_rlen_reg, req_rlen_next;
    logic [7:0] req_idx_reg, req_idx_next;
    logic       out_valid_reg, out_valid_next;

    logic [1:0]  status_reg, status_next;
    logic [31:0] code_reg, code_next;
    logic [5:0]  clen_reg, clen_next;
    logic [31:0] rbase_reg, rbase_next;
    logic [8:0]  rstart_reg, rstart_next;
    logic [8:0]  rcount_reg, rcount_next;
    logic [7:0]  ssym_reg, ssym_next;
    logic [8:0]  used_reg, used_next;
    logic [5:0]  maxl_reg, maxl_next;

    logic [5:0]  len_mem [chtb_pkg::NUM_SYMBOLS];
    logic [31:0] code_mem [chtb_pkg::NUM_SYMBOLS];
    logic [7:0]  sorted_mem [chtb_pkg::NUM_SYMBOLS];
    logic [5:0]  len_rdata_reg;
    logic [31:0] code_rdata_reg;
    logic [7:0]  sorted_rdata_reg;

    logic        len_we, code_we, sorted_we;
    logic [7:0]  len_waddr, code_waddr, sorted_waddr;
    logic [5:0]  len_wdata;
    logic [31:0] code_wdata;
    logic [7:0]  sorted_wdata;
    logic [7:0]  len_raddr, code_raddr, sorted_raddr;
    logic [8:0]  sweep_m1;
    logic [1:0]  base_status;
    logic        accept;

    chtb_pkg::row_ctrl_t row_ctrl;
    chtb_pkg::row_stat_t row_stat;

    chtb_row_unit u_rows (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (row_ctrl),
        .stat  (row_stat)
    );

    assign in_stall        = (state_reg != chtb_pkg::ST_IDLE) || out_valid_reg;
    assign accept          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign code            = code_reg;
    assign code_length     = clen_reg;
    assign row_base_code   = rbase_reg;
    assign row_start_index = rstart_reg;
    assign row_count       = rcount_reg;
    assign sorted_symbol   = ssym_reg;
    assign used_count      = used_reg;
    assign max_length      = maxl_reg;

    // state register and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chtb_pkg::ST_CLEAR;
            sweep_reg     <= '0;
            stale_reg     <= 1'b0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            stale_reg     <= stale_next;
            built_reg     <= built_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        req_func_reg <= req_func_next;
        req_sym_reg  <= req_sym_next;
        req_rlen_reg <= req_rlen_next;
        req_idx_reg  <= req_idx_next;
        status_reg   <= status_next;
        code_reg     <= code_next;
        clen_reg     <= clen_next;
        rbase_reg    <= rbase_next;
        rstart_reg   <= rstart_next;
        rcount_reg   <= rcount_next;
        ssym_reg     <= ssym_next;
        used_reg     <= used_next;
        maxl_reg     <= maxl_next;
    end

    // memories with registered read
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (code_we)
        begin
            code_mem[code_waddr] <= code_wdata;
        end
        if (sorted_we)
        begin
            sorted_mem[sorted_waddr] <= sorted_wdata;
        end
        len_rdata_reg    <= len_mem[len_raddr];
        code_rdata_reg   <= code_mem[code_raddr];
        sorted_rdata_reg <= sorted_mem[sorted_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        stale_next     = stale_reg;
        built_next     = built_reg;
        req_func_next  = req_func_reg;
        req_sym_next   = req_sym_reg;
        req_rlen_next  = req_rlen_reg;
        req_idx_next   = req_idx_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        code_next      = code_reg;
        clen_next      = clen_reg;
        rbase_next     = rbase_reg;
        rstart_next    = rstart_reg;
        rcount_next    = rcount_reg;
        ssym_next      = ssym_reg;
        used_next      = used_reg;
        maxl_next      = maxl_reg;

        len_we       = 1'b0;
        len_waddr    = sweep_reg[7:0];
        len_wdata    = '0;
        code_we      = 1'b0;
        code_waddr   = '0;
        code_wdata   = '0;
        sorted_we    = 1'b0;
        sorted_waddr = '0;
        sorted_wdata = '0;
        len_raddr    = sweep_reg[7:0];
        code_raddr   = req_sym_reg;
        sorted_raddr = req_idx_reg;
        sweep_m1     = sweep_reg - 9'd1;
        base_status  = row_stat.over ? chtb_pkg::STAT_OVER : chtb_pkg::STAT_OK;

        row_ctrl            = '0;
        row_ctrl.rd_len     = req_rlen_reg;
        row_ctrl.count_len  = len_rdata_reg;
        row_ctrl.assign_len = len_rdata_reg;
        row_ctrl.row_len    = sweep_reg[5:0] + 6'd1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // zero the length store after reset
            chtb_pkg::ST_CLEAR:
            begin
                len_we     = 1'b1;
                sweep_next = sweep_reg + 9'd1;
                if (sweep_reg[7:0] == 8'hFF)
                begin
                    sweep_next = '0;
                    state_next = chtb_pkg::ST_IDLE;
                end
            end
            chtb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == chtb_pkg::FUNC_WRITE)
                    begin
                        status_next = chtb_pkg::STAT_OK;
                        if (length > chtb_pkg::LEN_MAX)
                        begin
                            status_next = chtb_pkg::STAT_TOO_LARGE;
                        end
                        else
                        begin
                            len_we     = 1'b1;
                            len_waddr  = symbol;
                            len_wdata  = length;
                            stale_next = 1'b1;
                        end
                        code_next      = '0;
                        clen_next      = '0;
                        rbase_next     = '0;
                        rstart_next    = '1;
                        rcount_next    = '0;
                        ssym_next      = '0;
                        used_next      = '0;
                        maxl_next      = '0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        req_func_next = func;
                        req_sym_next  = symbol;
                        req_rlen_next = row_length;
                        req_idx_next  = entry_index;
                        if (stale_reg)
                        begin
                            row_ctrl.start = 1'b1;
                            sweep_next     = '0;
                            state_next     = chtb_pkg::ST_COUNT;
                        end
                        else
                        begin
                            state_next = chtb_pkg::ST_RD1;
                        end
                    end
                end
            end
            // histogram of lengths, data lags the address through the registered read
            chtb_pkg::ST_COUNT:
            begin
                if (sweep_reg != '0 && len_rdata_reg != '0)
                begin
                    row_ctrl.count_en = 1'b1;
                end
                sweep_next = sweep_reg + 9'd1;
                if (sweep_reg == chtb_pkg::SWEEP_END)
                begin
                    sweep_next = '0;
                    state_next = chtb_pkg::ST_ROWS;
                end
            end
            // one length row per cycle
            chtb_pkg::ST_ROWS:
            begin
                row_ctrl.row_en = 1'b1;
                sweep_next      = sweep_reg + 9'd1;
                if (sweep_reg == chtb_pkg::ROW_LAST)
                begin
                    sweep_next = '0;
                    state_next = chtb_pkg::ST_ASSIGN;
                end
            end
            // codes and sorted slots in symbol order
            chtb_pkg::ST_ASSIGN:
            begin
                if (sweep_reg != '0)
                begin
                    code_we    = 1'b1;
                    code_waddr = sweep_m1[7:0];
                    if (len_rdata_reg != '0)
                    begin
                        row_ctrl.assign_en = 1'b1;
                        code_wdata         = row_stat.assign_code;
                        sorted_we          = 1'b1;
                        sorted_waddr       = row_stat.assign_index;
                        sorted_wdata       = sweep_m1[7:0];
                    end
                end
                sweep_next = sweep_reg + 9'd1;
                if (sweep_reg == chtb_pkg::SWEEP_END)
                begin
                    sweep_next = '0;
                    stale_next = 1'b0;
                    built_next = 1'b1;
                    state_next = chtb_pkg::ST_RD1;
                end
            end
            chtb_pkg::ST_RD1:
            begin
                len_raddr  = req_sym_reg;
                state_next = chtb_pkg::ST_RD2;
            end
            chtb_pkg::ST_RD2:
            begin
                status_next    = base_status;
                code_next      = '0;
                clen_next      = '0;
                rbase_next     = '0;
                rstart_next    = '1;
                rcount_next    = '0;
                ssym_next      = '0;
                used_next      = row_stat.used;
                maxl_next      = row_stat.longest;
                out_valid_next = 1'b1;
                state_next     = chtb_pkg::ST_IDLE;
                case (req_func_reg)
                    chtb_pkg::FUNC_CODE:
                    begin
                        code_next = built_reg ? code_rdata_reg : '0;
                        clen_next = len_rdata_reg;
                    end
                    chtb_pkg::FUNC_ROW:
                    begin
                        if (req_rlen_reg > chtb_pkg::LEN_MAX)
                        begin
                            status_next = chtb_pkg::STAT_RANGE;
                        end
                        else if (req_rlen_reg != '0)
                        begin
                            rbase_next  = row_stat.rd_base;
                            rstart_next = row_stat.rd_start;
                            rcount_next = row_stat.rd_size;
                        end
                    end
                    chtb_pkg::FUNC_ENTRY:
                    begin
                        if ({1'b0, req_idx_reg} >= row_stat.used)
                        begin
                            status_next = chtb_pkg::STAT_RANGE;
                        end
                        else
                        begin
                            len_raddr      = sorted_rdata_reg;
                            code_raddr     = sorted_rdata_reg;
                            out_valid_next = out_valid_reg;
                            state_next     = chtb_pkg::ST_RD3;
                        end
                    end
                    default:
                    begin
                        status_next = base_status;
                    end
                endcase
            end
            chtb_pkg::ST_RD3:
            begin
                ssym_next      = sorted_rdata_reg;
                code_next      = code_rdata_reg;
                clen_next      = len_rdata_reg;
                out_valid_next = 1'b1;
                state_next     = chtb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chtb_pkg::ST_IDLE;
            end
        endcase
    end

    // a read while the tables are stale must go through a rebuild
    `CHTB_ASSERT_NXT(a_stale_rebuild, accept && func != chtb_pkg::FUNC_WRITE && stale_reg, state_reg == chtb_pkg::ST_COUNT)
    // the end of code assignment leaves fresh tables
    `CHTB_ASSERT_NXT(a_rebuild_done, state_reg == chtb_pkg::ST_ASSIGN && sweep_reg == chtb_pkg::SWEEP_END, !stale_reg && built_reg && state_reg == chtb_pkg::ST_RD1)
    // results only come from the write path or the read steps
    `CHTB_ASSERT_IMP(a_result_source, $rose(out_valid_reg), $past(state_reg) == chtb_pkg::ST_IDLE || $past(state_reg) == chtb_pkg::ST_RD2 || $past(state_reg) == chtb_pkg::ST_RD3)
endmodule
`default_nettype wire

FILE: hdl/chtb_row_unit.sv
// per-length row tables, length histogram and the shared code shifter
// depends on chtb_pkg
`default_nettype none
module chtb_row_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  chtb_pkg::row_ctrl_t  ctrl,
    output chtb_pkg::row_stat_t  stat
);
    localparam int ROWS = chtb_pkg::MAX_LEN;

    logic [chtb_pkg::CNT_W-1:0]  cnt_reg   [ROWS];
    logic [chtb_pkg::CODE_W-1:0] base_reg  [ROWS];
    logic [chtb_pkg::CNT_W-1:0]  start_reg [ROWS];
    logic [chtb_pkg::CNT_W-1:0]  size_reg  [ROWS];
    logic [chtb_pkg::CUR_W-1:0]  cur_reg;
    logic [chtb_pkg::LEN_W-1:0]  prev_reg;
    logic                        have_reg;
    logic [chtb_pkg::CNT_W-1:0]  n_reg;
    logic                        over_reg;
    logic [chtb_pkg::LEN_W-1:0]  longest_reg;

    logic [chtb_pkg::ROW_IDX_W-1:0] cidx, ridx, aidx, qidx;
    logic [chtb_pkg::LEN_W-1:0]     cm1, rm1, am1, qm1, shift_amt;
    logic [chtb_pkg::CNT_W-1:0]     row_cnt;
    logic [chtb_pkg::CUR_W-1:0]     shifted, sum, limit;

    // row indexes are length minus one
    always_comb
    begin
        cm1  = ctrl.count_len - 6'd1;
        rm1  = ctrl.row_len - 6'd1;
        am1  = ctrl.assign_len - 6'd1;
        qm1  = ctrl.rd_len - 6'd1;
        cidx = cm1[chtb_pkg::ROW_IDX_W-1:0];
        ridx = rm1[chtb_pkg::ROW_IDX_W-1:0];
        aidx = am1[chtb_pkg::ROW_IDX_W-1:0];
        qidx = qm1[chtb_pkg::ROW_IDX_W-1:0];
    end

    // shared shifter: base code of the next nonempty length
    always_comb
    begin
        row_cnt   = cnt_reg[ridx];
        shift_amt = have_reg ? (ctrl.row_len - prev_reg) : '0;
        shifted   = cur_reg << shift_amt;
        sum       = shifted + chtb_pkg::CUR_W'(row_cnt);
        limit     = chtb_pkg::CUR_W'(1) << ctrl.row_len;
    end

    // code and sorted slot for the next symbol of a length, plus row and summary outputs
    always_comb
    begin
        stat.assign_code  = base_reg[aidx] + chtb_pkg::CODE_W'(cnt_reg[aidx]);
        stat.assign_index = start_reg[aidx][chtb_pkg::SYM_W-1:0]
                          + cnt_reg[aidx][chtb_pkg::SYM_W-1:0];
        stat.rd_base      = base_reg[qidx];
        stat.rd_start     = start_reg[qidx];
        stat.rd_size      = size_reg[qidx];
        stat.used         = n_reg;
        stat.longest      = longest_reg;
        stat.over         = over_reg;
    end

    // histogram, row build and fill pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                cnt_reg[i]   <= '0;
                base_reg[i]  <= '0;
                start_reg[i] <= '1;
                size_reg[i]  <= '0;
            end
            cur_reg     <= '0;
            prev_reg    <= '0;
            have_reg    <= 1'b0;
            n_reg       <= '0;
            over_reg    <= 1'b0;
            longest_reg <= '0;
        end
        else if (ctrl.start)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            cur_reg     <= '0;
            prev_reg    <= '0;
            have_reg    <= 1'b0;
            n_reg       <= '0;
            over_reg    <= 1'b0;
            longest_reg <= '0;
        end
        else if (ctrl.count_en)
        begin
            cnt_reg[cidx] <= cnt_reg[cidx] + 9'd1;
        end
        else if (ctrl.row_en)
        begin
            cnt_reg[ridx] <= '0;
            if (row_cnt != '0)
            begin
                base_reg[ridx]  <= shifted[chtb_pkg::CODE_W-1:0];
                start_reg[ridx] <= n_reg;
                size_reg[ridx]  <= row_cnt;
                cur_reg         <= sum;
                prev_reg        <= ctrl.row_len;
                have_reg        <= 1'b1;
                n_reg           <= n_reg + row_cnt;
                longest_reg     <= ctrl.row_len;
                if (sum > limit)
                begin
                    over_reg <= 1'b1;
                end
            end
            else
            begin
                base_reg[ridx]  <= '0;
                start_reg[ridx] <= '1;
                size_reg[ridx]  <= '0;
            end
        end
        else if (ctrl.assign_en)
        begin
            cnt_reg[aidx] <= cnt_reg[aidx] + 9'd1;
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for the canonical huffman table builder
// depends on chtb_pkg and canonical_huffman_table_builder_top
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        chtb_pkg::func_t fn;
        logic [7:0]      sym;
        logic [5:0]      len;
        logic [5:0]      rlen;
        logic [7:0]      idx;
    } request_t;

    typedef struct {
        chtb_pkg::status_t  st;
        logic [31:0]        code;
        logic [5:0]         clen;
        logic [31:0]        rbase;
        logic signed [8:0]  rstart;
        logic [8:0]         rcount;
        logic [7:0]         ssym;
        logic [8:0]         used;
        logic [5:0]         maxl;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] func;
    logic [7:0] symbol;
    logic [5:0] length;
    logic [5:0] row_length;
    logic [7:0] entry_index;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [31:0] code;
    logic [5:0] code_length;
    logic [31:0] row_base_code;
    logic signed [8:0] row_start_index;
    logic [8:0] row_count;
    logic [7:0] sorted_symbol;
    logic [8:0] used_count;
    logic [5:0] max_length;

    canonical_huffman_table_builder_top dut (.*);

    // shadow copy of the code tables
    logic [5:0]  lens [chtb_pkg::NUM_SYMBOLS];
    logic [31:0] codes [chtb_pkg::NUM_SYMBOLS];
    logic [7:0]  order [chtb_pkg::NUM_SYMBOLS];
    logic [31:0] rbase_tab [chtb_pkg::MAX_LEN+1];
    logic signed [8:0] rstart_tab [chtb_pkg::MAX_LEN+1];
    logic [8:0]  rsize_tab [chtb_pkg::MAX_LEN+1];
    bit          stale;
    int          in_use;
    int          longest;
    bit          over;

    request_t pending_q[$];
    answer_t  expected_q[$];
    int errors = 0;
    int n_results = 0;
    int n_over = 0;
    bit pause_req = 0;
    bit taken = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // canonical code assignment in length then symbol order
    function automatic void rebuild_tables();
        logic [63:0] nxt;
        int prev;
        int n;
        bit ovr;
        nxt = 0;
        prev = 0;
        n = 0;
        ovr = 0;
        for (int i = 0; i < chtb_pkg::NUM_SYMBOLS; i++) codes[i] = '0;
        for (int i = 0; i <= chtb_pkg::MAX_LEN; i++)
        begin
            rbase_tab[i] = '0;
            rstart_tab[i] = '1;
            rsize_tab[i] = '0;
        end
        longest = 0;
        for (int l = 1; l <= chtb_pkg::MAX_LEN; l++)
        begin
            for (int s = 0; s < chtb_pkg::NUM_SYMBOLS; s++)
            begin
                if (lens[s] != l) continue;
                if (n == 0) prev = l;
                else if (l > prev)
                begin
                    nxt = nxt << (l - prev);
                    prev = l;
                end
                if ((nxt >> l) != 0) ovr = 1;
                codes[s] = nxt[31:0];
                if (rsize_tab[l] == 0)
                begin
                    rbase_tab[l] = nxt[31:0];
                    rstart_tab[l] = 9'(n);
                end
                rsize_tab[l]++;
                order[n] = 8'(s);
                n++;
                nxt++;
                longest = l;
            end
        end
        in_use = n;
        over = ovr;
        stale = 0;
    endfunction

    function automatic answer_t predict_answer(request_t r);
        answer_t a;
        a = '{chtb_pkg::STAT_OK, 0, 0, 0, -1, 0, 0, 0, 0};
        if (r.fn == chtb_pkg::FUNC_WRITE)
        begin
            if (r.len > chtb_pkg::MAX_LEN) a.st = chtb_pkg::STAT_TOO_LARGE;
            else
            begin
                lens[r.sym] = r.len;
                stale = 1;
            end
            return a;
        end
        if (stale) rebuild_tables();
        a.st = over ? chtb_pkg::STAT_OVER : chtb_pkg::STAT_OK;
        a.used = 9'(in_use);
        a.maxl = 6'(longest);
        case (r.fn)
            chtb_pkg::FUNC_CODE:
            begin
                a.code = codes[r.sym];
                a.clen = lens[r.sym];
            end
            chtb_pkg::FUNC_ROW:
            begin
                if (r.rlen > chtb_pkg::MAX_LEN) a.st = chtb_pkg::STAT_RANGE;
                else if (r.rlen > 0)
                begin
                    a.rbase = rbase_tab[r.rlen];
                    a.rstart = rstart_tab[r.rlen];
                    a.rcount = rsize_tab[r.rlen];
                end
            end
            default:
            begin
                if (r.idx >= in_use) a.st = chtb_pkg::STAT_RANGE;
                else
                begin
                    a.ssym = order[r.idx];
                    a.code = codes[order[r.idx]];
                    a.clen = lens[order[r.idx]];
                end
            end
        endcase
        return a;
    endfunction

    function automatic request_t mk(chtb_pkg::func_t f, int s, int l, int rl, int ix);
        request_t r;
        r.fn = f;
        r.sym = 8'(s);
        r.len = 6'(l);
        r.rlen = 6'(rl);
        r.idx = 8'(ix);
        return r;
    endfunction

    function automatic request_t random_read();
        return mk(chtb_pkg::func_t'($urandom_range(3, 1)), $urandom_range(255),
                  $urandom_range(63),
                  $urandom_range(63) < 40 ? $urandom_range(33) : $urandom_range(63),
                  $urandom_range(255));
    endfunction

    // sender: bursts and gaps, holds payload until the request is taken
    int gap = 0;
    int burst = 0;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken))
        begin
            taken = 0;
            if (pause_req || pending_q.size() == 0)
                in_valid <= 0;
            else if (gap > 0)
            begin
                gap--;
                in_valid <= 0;
            end
            else
            begin
                in_valid <= 1;
                func <= pending_q[0].fn;
                symbol <= pending_q[0].sym;
                length <= pending_q[0].len;
                row_length <= pending_q[0].rlen;
                entry_index <= pending_q[0].idx;
                if (burst > 0) burst--;
                else
                begin
                    burst = $urandom_range(20);
                    gap = $urandom_range(3) == 0 ? $urandom_range(6) : 0;
                end
            end
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9]) out_stall <= 0;
        else out_stall <= ($urandom_range(3) == 0);
    end

    // predictor on accepted requests
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_q.push_back(predict_answer(pending_q[0]));
            void'(pending_q.pop_front());
            taken = 1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("result with no request outstanding");
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.st == chtb_pkg::STAT_OVER) n_over++;
                if (status !== e.st)
                begin
                    errors++;
                    $error("status exp %0d got %0d", e.st, status);
                end
                if (code !== e.code)
                begin
                    errors++;
                    $error("code exp %h got %h", e.code, code);
                end
                if (code_length !== e.clen)
                begin
                    errors++;
                    $error("code_length exp %0d got %0d", e.clen, code_length);
                end
                if (row_base_code !== e.rbase)
                begin
                    errors++;
                    $error("row_base_code exp %h got %h", e.rbase, row_base_code);
                end
                if (row_start_index !== e.rstart)
                begin
                    errors++;
                    $error("row_start_index exp %0d got %0d", e.rstart, row_start_index);
                end
                if (row_count !== e.rcount)
                begin
                    errors++;
                    $error("row_count exp %0d got %0d", e.rcount, row_count);
                end
                if (sorted_symbol !== e.ssym)
                begin
                    errors++;
                    $error("sorted_symbol exp %0d got %0d", e.ssym, sorted_symbol);
                end
                if (used_count !== e.used)
                begin
                    errors++;
                    $error("used_count exp %0d got %0d", e.used, used_count);
                end
                if (max_length !== e.maxl)
                begin
                    errors++;
                    $error("max_length exp %0d got %0d", e.maxl, max_length);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int lset [chtb_pkg::NUM_SYMBOLS];
        int nsym;
        int base;
        int kind;
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        func = chtb_pkg::FUNC_WRITE;
        symbol = 0;
        length = 0;
        row_length = 0;
        entry_index = 0;
        for (int i = 0; i < chtb_pkg::NUM_SYMBOLS; i++)
        begin
            lens[i] = '0;
            codes[i] = '0;
            order[i] = '0;
        end
        for (int i = 0; i <= chtb_pkg::MAX_LEN; i++)
        begin
            rbase_tab[i] = '0;
            rstart_tab[i] = '1;
            rsize_tab[i] = '0;
        end
        stale = 0;
        in_use = 0;
        longest = 0;
        over = 0;
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1;

        // directed: empty set, extremes, too-large write, row edges, oversubscription
        pending_q.push_back(mk(chtb_pkg::FUNC_CODE, 0, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ENTRY, 0, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 0, 63, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 0, 33, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 255, 32, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 0, 1, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 7, 2, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_CODE, 255, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 32, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 33, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 63, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ENTRY, 0, 0, 0, 2));
        pending_q.push_back(mk(chtb_pkg::FUNC_ENTRY, 0, 0, 0, 3));
        pending_q.push_back(mk(chtb_pkg::FUNC_ENTRY, 0, 0, 0, 255));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 1, 1, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 2, 1, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_CODE, 2, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 1, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 2, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, 2, 0, 0, 0));
        pending_q.push_back(mk(chtb_pkg::FUNC_ENTRY, 0, 0, 0, 1));

        // let everything drain before the random part
        wait (pending_q.size() == 0 && !in_valid);
        pause_req = 1;
        wait (expected_q.size() == 0);
        pause_req = 0;

        // random: mostly complete length sets then many reads
        for (int k = 0; k < 15; k++)
        begin
            kind = $urandom_range(9);
            nsym = $urandom_range(3) == 0 ? $urandom_range(255, 2) : $urandom_range(20, 2);
            base = $urandom_range(255);
            if (kind < 6)
            begin
                // complete prefix code: split randomly chosen leaves
                for (int i = 0; i < chtb_pkg::NUM_SYMBOLS; i++) lset[i] = 0;
                lset[0] = 1;
                lset[1] = 1;
                for (int i = 2; i < nsym; i++)
                begin
                    int j;
                    j = $urandom_range(i - 1);
                    if (lset[j] >= chtb_pkg::MAX_LEN) j = 0;
                    if (lset[j] >= chtb_pkg::MAX_LEN) break;
                    lset[j]++;
                    lset[i] = lset[j];
                end
                for (int i = 0; i < nsym; i++)
                    pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, (base + i * 37) % 256,
                                           lset[i], 0, 0));
            end
            else
            begin
                // noise: random lengths, some oversubscribed or too large
                for (int i = 0; i < nsym; i++)
                    pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, $urandom_range(255),
                        kind == 9 ? $urandom_range(63) : $urandom_range(4), 0, 0));
            end
            for (int i = 0; i < 30; i++) pending_q.push_back(random_read());
            if ($urandom_range(4) == 0)
                for (int i = 0; i < chtb_pkg::NUM_SYMBOLS; i++)
                    pending_q.push_back(mk(chtb_pkg::FUNC_WRITE, i, 0, 0, 0));
        end
        pending_q.push_back(mk(chtb_pkg::FUNC_ROW, 0, 0, 0, 0));

        wait (pending_q.size() == 0 && !in_valid);
        wait (expected_q.size() == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d results, %0d with oversubscribed sets", n_results, n_over);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
